FILE: sv/mphr_pkg.sv
// Shared types, constants and a saturation helper for the moving harmonic wall pipeline.
package mphr_pkg;

    // Number of register stages from input transfer to output register.
    localparam int NSTG = 9;

    // Field widths.
    localparam int STEP_W  = 40;
    localparam int POS_W   = 32;
    localparam int FORCE_W = 32;
    localparam int ENER_W  = 48;
    localparam int K_W     = 32;
    localparam int OFF_W   = 32;
    localparam int VEL_W   = 40;
    localparam int NRM_W   = 18;
    localparam int CFG_W   = 40;
    localparam int IDX_W   = 3;

    // Largest plane shift magnitude, Q32.16.
    localparam logic [47:0] SHIFT_CAP = 48'h8000_0000_0000;

    // Force saturation limits.
    localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [FORCE_W-1:0] FORCE_NEG_MIN = 32'h8000_0000;

    // Reset values of the configuration registers.
    localparam logic [K_W-1:0]   STIFF_RST = 32'h0001_0000;
    localparam logic [NRM_W-1:0] NX_RST    = 18'h1_0000;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_STIFFNESS    = 3'd0,
        CFG_START_OFFSET = 3'd1,
        CFG_END_OFFSET   = 3'd2,
        CFG_VELOCITY     = 3'd3,
        CFG_NORMAL_X     = 3'd4,
        CFG_NORMAL_Y     = 3'd5,
        CFG_NORMAL_Z     = 3'd6
    } t_cfg_idx;

    // Final force component: r is the scaled magnitude, big flags an early overflow.
    function automatic logic [FORCE_W-1:0] force_sat(
        input logic        big,
        input logic [49:0] r,
        input logic        n_neg,
        input logic        n_zero
    );
        logic [FORCE_W-1:0] res;
        if (n_zero) begin
            res = '0;
        end else if (!n_neg) begin
            res = (big || r > 50'h0_7FFF_FFFF) ? FORCE_POS_MAX : r[FORCE_W-1:0];
        end else begin
            res = (big || r > 50'h0_8000_0000) ? FORCE_NEG_MIN
                                                : 32'h0 - r[FORCE_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/moving_plane_harmonic_repulsion.sv
// Nine-stage pipeline computing the force and energy of a moving harmonic wall plane.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_sim_step, i_pos_x/y/z
//  out     | output    | o_out_valid / i_out_ready | o_force_x/y/z, o_energy
//  cfg     | input     | i_cfg_we (no handshake)   | i_cfg_index, i_cfg_wdata
//
// One item per cycle is taken unless a stalled output has filled every stage; a result is
// valid once it reaches the output register and leaves on the first edge with i_out_ready high.
// The latency is set by the chain of split multipliers (plane shift, dot product,
// penetration times stiffness, penetration squared times stiffness), one product row per stage.
// Each stage holds its own valid bit and loads whenever it is empty or its successor moves,
// so a stall on the output only holds items up to the first empty stage.
// Synchronous active-low reset clears the valid bits and restores the configuration defaults.
module moving_plane_harmonic_repulsion
    import mphr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port.
    input  logic                      i_cfg_we,
    input  logic [IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    // Input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [STEP_W-1:0]         i_sim_step,
    input  logic signed [POS_W-1:0]   i_pos_x,
    input  logic signed [POS_W-1:0]   i_pos_y,
    input  logic signed [POS_W-1:0]   i_pos_z,
    // Output channel.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [FORCE_W-1:0] o_force_x,
    output logic signed [FORCE_W-1:0] o_force_y,
    output logic signed [FORCE_W-1:0] o_force_z,
    output logic [ENER_W-1:0]         o_energy
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [K_W-1:0]            r_stiff;
    logic signed [OFF_W-1:0]   r_start;
    logic signed [OFF_W-1:0]   r_end;
    logic signed [VEL_W-1:0]   r_vel;
    logic signed [NRM_W-1:0]   r_nx;
    logic signed [NRM_W-1:0]   r_ny;
    logic signed [NRM_W-1:0]   r_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= STIFF_RST;
            r_start <= '0;
            r_end   <= '0;
            r_vel   <= '0;
            r_nx    <= NX_RST;
            r_ny    <= '0;
            r_nz    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STIFFNESS:    r_stiff <= i_cfg_wdata[K_W-1:0];
                CFG_START_OFFSET: r_start <= i_cfg_wdata[OFF_W-1:0];
                CFG_END_OFFSET:   r_end   <= i_cfg_wdata[OFF_W-1:0];
                CFG_VELOCITY:     r_vel   <= i_cfg_wdata[VEL_W-1:0];
                CFG_NORMAL_X:     r_nx    <= i_cfg_wdata[NRM_W-1:0];
                CFG_NORMAL_Y:     r_ny    <= i_cfg_wdata[NRM_W-1:0];
                CFG_NORMAL_Z:     r_nz    <= i_cfg_wdata[NRM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Magnitudes of the velocity and the normal components.
    logic [VEL_W-1:0] w_vel_abs;
    logic [NRM_W-1:0] w_anx;
    logic [NRM_W-1:0] w_any;
    logic [NRM_W-1:0] w_anz;

    assign w_vel_abs = r_vel[VEL_W-1] ? VEL_W'(-r_vel) : r_vel;
    assign w_anx     = r_nx[NRM_W-1] ? NRM_W'(-r_nx) : r_nx;
    assign w_any     = r_ny[NRM_W-1] ? NRM_W'(-r_ny) : r_ny;
    assign w_anz     = r_nz[NRM_W-1] ? NRM_W'(-r_nz) : r_nz;

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when its successor moves.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   w_take;
    logic            w_in_xfer;
    logic            w_out_xfer;

    always_comb begin
        w_take[NSTG] = i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
        if (w_take[0]) begin
            n_vld[0] = i_in_valid;
        end else begin
            n_vld[0] = r_vld[0];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_take[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_take[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_xfer  = o_out_valid && i_out_ready;

    // ------------------------------------------------------------------
    // Stage 1: velocity times step halves, normal times position products.
    // ------------------------------------------------------------------
    logic [59:0]        n_s1_vp_lo, r_s1_vp_lo;
    logic [59:0]        n_s1_vp_hi, r_s1_vp_hi;
    logic signed [49:0] n_s1_dx, r_s1_dx;
    logic signed [49:0] n_s1_dy, r_s1_dy;
    logic signed [49:0] n_s1_dz, r_s1_dz;

    always_comb begin
        n_s1_vp_lo = w_vel_abs * i_sim_step[19:0];
        n_s1_vp_hi = w_vel_abs * i_sim_step[39:20];
        n_s1_dx    = r_nx * i_pos_x;
        n_s1_dy    = r_ny * i_pos_y;
        n_s1_dz    = r_nz * i_pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_take[0]) begin
            r_s1_vp_lo <= n_s1_vp_lo;
            r_s1_vp_hi <= n_s1_vp_hi;
            r_s1_dx    <= n_s1_dx;
            r_s1_dy    <= n_s1_dy;
            r_s1_dz    <= n_s1_dz;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: full velocity product and the dot product sum.
    // ------------------------------------------------------------------
    logic [79:0]        n_s2_vprod, r_s2_vprod;
    logic signed [51:0] n_s2_dot, r_s2_dot;

    always_comb begin
        n_s2_vprod = {r_s1_vp_hi, 20'b0} + {20'b0, r_s1_vp_lo};
        n_s2_dot   = 52'(r_s1_dx) + 52'(r_s1_dy) + 52'(r_s1_dz);
    end

    always_ff @(posedge i_clk) begin
        if (w_take[1]) begin
            r_s2_vprod <= n_s2_vprod;
            r_s2_dot   <= n_s2_dot;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: capped shift magnitude and the dot product floored to Q16.16.
    // ------------------------------------------------------------------
    logic [47:0]        n_s3_sh, r_s3_sh;
    logic signed [35:0] n_s3_dq, r_s3_dq;

    always_comb begin
        if ((|r_s2_vprod[79:64]) || r_s2_vprod[63:16] > SHIFT_CAP) begin
            n_s3_sh = SHIFT_CAP;
        end else begin
            n_s3_sh = r_s2_vprod[63:16];
        end
        n_s3_dq = r_s2_dot[51:16];
    end

    always_ff @(posedge i_clk) begin
        if (w_take[2]) begin
            r_s3_sh <= n_s3_sh;
            r_s3_dq <= n_s3_dq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: plane offset, clamped at the end offset on the side away from the start.
    // ------------------------------------------------------------------
    logic signed [48:0] w_st49;
    logic signed [48:0] w_en49;
    logic signed [48:0] w_sh49;
    logic signed [48:0] w_off_raw;
    logic signed [48:0] n_s4_off, r_s4_off;
    logic signed [35:0] r_s4_dq;

    always_comb begin
        w_st49    = 49'(r_start);
        w_en49    = 49'(r_end);
        w_sh49    = signed'({1'b0, r_s3_sh});
        w_off_raw = r_vel[VEL_W-1] ? w_st49 - w_sh49 : w_st49 + w_sh49;
        if (w_en49 > w_st49 && w_off_raw > w_en49) begin
            n_s4_off = w_en49;
        end else if (w_en49 < w_st49 && w_off_raw < w_en49) begin
            n_s4_off = w_en49;
        end else begin
            n_s4_off = w_off_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[3]) begin
            r_s4_off <= n_s4_off;
            r_s4_dq  <= r_s3_dq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: signed distance, inside flag and penetration depth.
    // ------------------------------------------------------------------
    logic signed [48:0] w_s5_dist;
    logic [47:0]        n_s5_m, r_s5_m;
    logic               r_s5_neg;

    always_comb begin
        w_s5_dist = 49'(r_s4_dq) + r_s4_off;
        n_s5_m    = 48'(-w_s5_dist);
    end

    always_ff @(posedge i_clk) begin
        if (w_take[4]) begin
            r_s5_m   <= n_s5_m;
            r_s5_neg <= w_s5_dist[48];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: partial products of depth times stiffness and depth squared.
    // ------------------------------------------------------------------
    logic [55:0] n_s6_mk_h, r_s6_mk_h;
    logic [55:0] n_s6_mk_l, r_s6_mk_l;
    logic [33:0] n_s6_hh, r_s6_hh;
    logic [40:0] n_s6_hl, r_s6_hl;
    logic [47:0] n_s6_ll, r_s6_ll;
    logic        r_s6_ebig;
    logic        r_s6_neg;

    always_comb begin
        n_s6_mk_h = r_s5_m[47:24] * r_stiff;
        n_s6_mk_l = r_s5_m[23:0] * r_stiff;
        n_s6_hh   = r_s5_m[40:24] * r_s5_m[40:24];
        n_s6_hl   = r_s5_m[40:24] * r_s5_m[23:0];
        n_s6_ll   = r_s5_m[23:0] * r_s5_m[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_take[5]) begin
            r_s6_mk_h <= n_s6_mk_h;
            r_s6_mk_l <= n_s6_mk_l;
            r_s6_hh   <= n_s6_hh;
            r_s6_hl   <= n_s6_hl;
            r_s6_ll   <= n_s6_ll;
            // Depth of 2^41 or more squares past the energy limit.
            r_s6_ebig <= |r_s5_m[47:41];
            r_s6_neg  <= r_s5_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: assemble the scaled force magnitude and the squared depth.
    // ------------------------------------------------------------------
    logic [79:0] w_s7_mk;
    logic [81:0] w_s7_m2;
    logic [47:0] r_s7_q;
    logic        r_s7_qbig;
    logic [80:0] r_s7_m2;
    logic        r_s7_esat;
    logic        r_s7_neg;

    always_comb begin
        w_s7_mk = {r_s6_mk_h, 24'b0} + {24'b0, r_s6_mk_l};
        w_s7_m2 = {r_s6_hh, 48'b0} + {16'b0, r_s6_hl, 25'b0} + {34'b0, r_s6_ll};
    end

    always_ff @(posedge i_clk) begin
        if (w_take[6]) begin
            r_s7_q    <= w_s7_mk[63:16];
            // A magnitude of 2^48 or more overflows any nonzero normal component.
            r_s7_qbig <= |w_s7_mk[79:64];
            r_s7_m2   <= w_s7_m2[80:0];
            r_s7_esat <= r_s6_ebig || w_s7_m2[81];
            r_s7_neg  <= r_s6_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: force times normal magnitudes, squared depth times stiffness.
    // ------------------------------------------------------------------
    logic [65:0] n_s8_fx, r_s8_fx;
    logic [65:0] n_s8_fy, r_s8_fy;
    logic [65:0] n_s8_fz, r_s8_fz;
    logic [58:0] n_s8_p0, r_s8_p0;
    logic [58:0] n_s8_p1, r_s8_p1;
    logic [58:0] n_s8_p2, r_s8_p2;
    logic        r_s8_qbig;
    logic        r_s8_esat;
    logic        r_s8_neg;

    always_comb begin
        n_s8_fx = r_s7_q * w_anx;
        n_s8_fy = r_s7_q * w_any;
        n_s8_fz = r_s7_q * w_anz;
        n_s8_p0 = r_s7_m2[26:0] * r_stiff;
        n_s8_p1 = r_s7_m2[53:27] * r_stiff;
        n_s8_p2 = r_s7_m2[80:54] * r_stiff;
    end

    always_ff @(posedge i_clk) begin
        if (w_take[7]) begin
            r_s8_fx   <= n_s8_fx;
            r_s8_fy   <= n_s8_fy;
            r_s8_fz   <= n_s8_fz;
            r_s8_p0   <= n_s8_p0;
            r_s8_p1   <= n_s8_p1;
            r_s8_p2   <= n_s8_p2;
            r_s8_qbig <= r_s7_qbig;
            r_s8_esat <= r_s7_esat;
            r_s8_neg  <= r_s7_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: saturation, sign and the outside-the-wall zeroing.
    // ------------------------------------------------------------------
    logic [112:0]        w_s9_t;
    logic                w_s9_esat;
    logic [FORCE_W-1:0]  n_s9_fx, r_s9_fx;
    logic [FORCE_W-1:0]  n_s9_fy, r_s9_fy;
    logic [FORCE_W-1:0]  n_s9_fz, r_s9_fz;
    logic [ENER_W-1:0]   n_s9_e, r_s9_e;

    always_comb begin
        w_s9_t    = {r_s8_p2, 54'b0} + {27'b0, r_s8_p1, 27'b0} + {54'b0, r_s8_p0};
        w_s9_esat = (r_s8_esat && r_stiff != '0) || (|w_s9_t[112:81]);
        if (r_s8_neg) begin
            n_s9_fx = force_sat(r_s8_qbig, r_s8_fx[65:16], r_nx[NRM_W-1], r_nx == '0);
            n_s9_fy = force_sat(r_s8_qbig, r_s8_fy[65:16], r_ny[NRM_W-1], r_ny == '0);
            n_s9_fz = force_sat(r_s8_qbig, r_s8_fz[65:16], r_nz[NRM_W-1], r_nz == '0);
            n_s9_e  = w_s9_esat ? '1 : w_s9_t[80:33];
        end else begin
            n_s9_fx = '0;
            n_s9_fy = '0;
            n_s9_fz = '0;
            n_s9_e  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[8]) begin
            r_s9_fx <= n_s9_fx;
            r_s9_fy <= n_s9_fy;
            r_s9_fz <= n_s9_fz;
            r_s9_e  <= n_s9_e;
        end
    end

    assign o_force_x = r_s9_fx;
    assign o_force_y = r_s9_fy;
    assign o_force_z = r_s9_fz;
    assign o_energy  = r_s9_e;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The item count in flight changes only by input and output transfers.
    a_count_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_vld) + 32'($past(w_out_xfer))
             == $past($countones(r_vld)) + 32'($past(w_in_xfer))))
        else $error("pipeline item count does not match the transfers");

    // An accepted input lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_vld[0])
        else $error("accepted input missing from the first stage");

    // An empty output register never holds off the input.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked while the output register is empty");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the moving harmonic wall force and energy pipeline.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mphr_pkg::*;

    localparam int CYCLE_LIMIT     = 200_000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES   = 16;

    // Wall registers as the block holds them.
    typedef struct packed {
        logic [K_W-1:0]          stiff;
        logic signed [OFF_W-1:0] start_off;
        logic signed [OFF_W-1:0] end_off;
        logic signed [VEL_W-1:0] vel;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
    } t_wall_regs;

    typedef struct packed {
        logic [STEP_W-1:0]       sim_step;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
    } t_particle;

    typedef struct packed {
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
        logic signed [FORCE_W-1:0] fz;
        logic [ENER_W-1:0]         energy;
    } t_wall_resp;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_wdata = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [STEP_W-1:0]         i_sim_step = '0;
    logic signed [POS_W-1:0]   i_pos_x = '0;
    logic signed [POS_W-1:0]   i_pos_y = '0;
    logic signed [POS_W-1:0]   i_pos_z = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b1;
    logic signed [FORCE_W-1:0] o_force_x;
    logic signed [FORCE_W-1:0] o_force_y;
    logic signed [FORCE_W-1:0] o_force_z;
    logic [ENER_W-1:0]         o_energy;

    t_wall_regs wall_cfg = '{STIFF_RST, '0, '0, '0, NX_RST, '0, '0};
    t_wall_resp expected_resp[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         ready_hold = 0;
    bit         send_idle_on = 1'b1;
    bit         recv_idle_on = 1'b1;

    moving_plane_harmonic_repulsion DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sim_step  (i_sim_step),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_force_x   (o_force_x),
        .o_force_y   (o_force_y),
        .o_force_z   (o_force_z),
        .o_energy    (o_energy)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Force along one normal component for a penetration depth pen.
    function automatic logic signed [FORCE_W-1:0] wall_force(
        input logic [63:0]             pen,
        input logic [K_W-1:0]          k,
        input logic signed [NRM_W-1:0] n
    );
        logic [NRM_W-1:0] nmag;
        logic [127:0]     spring, scaled;
        logic [63:0]      mag;
        logic             big;
        nmag = n[NRM_W-1] ? NRM_W'(-n) : NRM_W'(n);
        if (nmag == '0 || k == '0) begin
            return '0;
        end
        spring = 128'(pen) * 128'(k);
        scaled = 128'(spring[79:16]) * 128'(nmag);
        big = (spring[127:80] != '0) || (scaled[127:80] != '0);
        mag = scaled[79:16];
        if (!n[NRM_W-1]) begin
            return (big || mag > 64'h7FFF_FFFF) ? FORCE_POS_MAX : mag[FORCE_W-1:0];
        end
        return (big || mag > 64'h8000_0000) ? FORCE_NEG_MIN : 32'h0 - mag[FORCE_W-1:0];
    endfunction

    // Expected force and energy for one particle under the given wall settings.
    function automatic t_wall_resp predict_wall_response(
        input t_wall_regs r,
        input t_particle  p
    );
        t_wall_resp         res;
        logic [VEL_W-1:0]   vmag;
        logic [79:0]        travel;
        logic [63:0]        shift, pen;
        logic [191:0]       e_full;
        logic signed [63:0] st, en, off, dot, wall_gap;
        logic signed [63:0] n_x, n_y, n_z, q_x, q_y, q_z;
        res = '0;
        // Plane travel since step zero, capped, then held at the end offset.
        vmag = r.vel[VEL_W-1] ? VEL_W'(-r.vel) : VEL_W'(r.vel);
        travel = 80'(vmag) * 80'(p.sim_step);
        shift = travel[79:16];
        if (shift > 64'(SHIFT_CAP)) begin
            shift = 64'(SHIFT_CAP);
        end
        st = $signed(r.start_off);
        en = $signed(r.end_off);
        off = r.vel[VEL_W-1] ? st - $signed(shift) : st + $signed(shift);
        if (en > st && off > en) begin
            off = en;
        end
        if (en < st && off < en) begin
            off = en;
        end
        // Exact dot product, floored to Q16.16, plus the plane offset.
        n_x = $signed(r.nx);
        n_y = $signed(r.ny);
        n_z = $signed(r.nz);
        q_x = $signed(p.px);
        q_y = $signed(p.py);
        q_z = $signed(p.pz);
        dot = n_x * q_x + n_y * q_y + n_z * q_z;
        wall_gap = (dot >>> 16) + off;
        if (wall_gap >= 0) begin
            return res;
        end
        pen = -wall_gap;
        res.fx = wall_force(pen, r.stiff, r.nx);
        res.fy = wall_force(pen, r.stiff, r.ny);
        res.fz = wall_force(pen, r.stiff, r.nz);
        if (r.stiff != '0) begin
            e_full = 192'(pen) * 192'(pen) * 192'(r.stiff);
            res.energy = (e_full[191:81] != '0) ? '1 : e_full[80:33];
        end
        return res;
    endfunction

    // Compare one result field and report a mismatch.
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Check every result transfer and pace the output ready.
    always @(posedge i_clk) begin : result_check
        t_wall_resp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_resp.size() == 0) begin
                $display("%0t: result with none expected: expected none, actual %h %h %h %h",
                         $time, o_force_x, o_force_y, o_force_z, o_energy);
                mismatch_count++;
            end else begin
                want = expected_resp.pop_front();
                check_field("force_x", 64'(want.fx), 64'(o_force_x));
                check_field("force_y", 64'(want.fy), 64'(o_force_y));
                check_field("force_z", 64'(want.fz), 64'(o_force_z));
                check_field("energy", 64'(want.energy), 64'(o_energy));
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
            if (ready_hold == 0) begin
                i_out_ready <= 1'b1;
            end
        end else if (o_out_valid && i_out_ready && recv_idle_on) begin
            ready_hold = $urandom_range(0, 7);
            if (ready_hold > 0) begin
                i_out_ready <= 1'b0;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // One particle transfer. Valid stays high afterwards so back-to-back items
    // need no extra edge; an idle gap in the next call or the drain lowers it.
    task automatic send_particle(input logic [STEP_W-1:0] sim_step,
                                 input logic [POS_W-1:0] px,
                                 input logic [POS_W-1:0] py,
                                 input logic [POS_W-1:0] pz);
        t_particle p;
        int        gap;
        p = '{sim_step, px, py, pz};
        gap = send_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sim_step <= p.sim_step;
        i_pos_x    <= p.px;
        i_pos_y    <= p.py;
        i_pos_z    <= p.pz;
        do @(posedge i_clk); while (!o_in_ready);
        expected_resp.push_back(predict_wall_response(wall_cfg, p));
    endtask

    // Stop sending and wait until every expected result has been seen.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_resp.size() != 0);
    endtask

    // One register write; bits above the register width carry noise.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value,
                             input int width);
        logic [CFG_W-1:0] keep;
        keep = ~({CFG_W{1'b1}} << width);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= (value & keep) | (CFG_W'({$urandom, $urandom}) & ~keep);
        @(posedge i_clk);
    endtask

    // Load all wall registers; only called with the pipeline empty.
    task automatic program_wall(input t_wall_regs r);
        write_reg(CFG_STIFFNESS, CFG_W'(r.stiff), K_W);
        write_reg(CFG_START_OFFSET, CFG_W'(r.start_off), OFF_W);
        write_reg(CFG_END_OFFSET, CFG_W'(r.end_off), OFF_W);
        write_reg(CFG_VELOCITY, CFG_W'(r.vel), VEL_W);
        write_reg(CFG_NORMAL_X, CFG_W'(r.nx), NRM_W);
        write_reg(CFG_NORMAL_Y, CFG_W'(r.ny), NRM_W);
        write_reg(CFG_NORMAL_Z, CFG_W'(r.nz), NRM_W);
        i_cfg_we <= 1'b0;
        wall_cfg = r;
    endtask

    // Random wall settings: mostly moderate, sometimes at the extremes.
    function automatic t_wall_regs random_wall();
        t_wall_regs              r;
        logic signed [NRM_W-1:0] unit_n;
        case ($urandom_range(0, 7))
            0:       r.stiff = '0;
            1:       r.stiff = '1;
            2, 3:    r.stiff = $urandom;
            default: r.stiff = $urandom_range(1, 32'h0010_0000);
        endcase
        r.start_off = ($urandom_range(0, 7) < 6)
                    ? 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000 : $urandom;
        r.end_off = ($urandom_range(0, 7) < 6)
                  ? 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000 : $urandom;
        if ($urandom_range(0, 5) == 0) begin
            r.end_off = r.start_off;
        end
        case ($urandom_range(0, 5))
            0:       r.vel = '0;
            1:       r.vel = VEL_W'({$urandom, $urandom});
            2:       r.vel = $urandom_range(0, 1) ? 40'h7F_FFFF_FFFF : 40'h80_0000_0000;
            default: r.vel = VEL_W'($urandom_range(0, 32'h0400_0000)) - 40'h00_0200_0000;
        endcase
        case ($urandom_range(0, 3))
            0: begin
                unit_n = $urandom_range(0, 1) ? NX_RST : NRM_W'(-NX_RST);
                r.nx = '0;
                r.ny = '0;
                r.nz = '0;
                case ($urandom_range(0, 2))
                    0:       r.nx = unit_n;
                    1:       r.ny = unit_n;
                    default: r.nz = unit_n;
                endcase
            end
            1: begin
                r.nx = NRM_W'($urandom_range(0, 92682)) - NRM_W'(46341);
                r.ny = NRM_W'($urandom_range(0, 92682)) - NRM_W'(46341);
                r.nz = NRM_W'($urandom_range(0, 92682)) - NRM_W'(46341);
            end
            2: begin
                r.nx = NRM_W'($urandom);
                r.ny = NRM_W'($urandom);
                r.nz = NRM_W'($urandom);
            end
            default: begin
                r.nx = NX_RST;
                r.ny = '0;
                r.nz = '0;
            end
        endcase
        return r;
    endfunction

    // Settings out of reset: unit x normal, unit stiffness, fixed plane at zero.
    task automatic test_reset_defaults();
        send_particle(40'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_particle(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_particle(40'd0, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        send_particle(40'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    // Moving plane: stop at the end offset both ways, and the travel cap.
    task automatic test_plane_motion();
        // Moves up by one unit per step from -16 and stops at +16.
        program_wall('{32'h0001_0000, 32'hFFF0_0000, 32'h0010_0000, 40'h01_0000_0000,
                       NX_RST, 18'h0_0000, 18'h0_0000});
        send_particle(40'd0, 32'h000F_FFFF, 32'h0, 32'h0);
        send_particle(40'd10, 32'h0000_0000, 32'h0, 32'h0);
        send_particle(40'd40, 32'hFFF0_0000, 32'h0, 32'h0);
        send_particle(40'hFF_FFFF_FFFF, 32'hFFEF_FFFF, 32'h0, 32'h0);
        wait_drained();
        // Moves down from +16 and stops at -16, with a negative normal.
        program_wall('{32'h0001_0000, 32'h0010_0000, 32'hFFF0_0000, 40'hFF_0000_0000,
                       18'h3_0000, 18'h0_0000, 18'h0_0000});
        send_particle(40'd0, 32'h0010_0001, 32'h0, 32'h0);
        send_particle(40'd100, 32'hFFF0_0000, 32'h0, 32'h0);
        wait_drained();
        // Equal start and end leave the plane free; fastest velocity hits the cap.
        program_wall('{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 40'h80_0000_0000,
                       18'h0_0000, NX_RST, 18'h0_0000});
        send_particle(40'hFF_FFFF_FFFF, 32'h0, 32'h0000_0000, 32'h0);
        send_particle(40'd1, 32'h0, 32'h0000_0000, 32'h0);
        wait_drained();
    endtask

    // Force and energy saturation, zero stiffness, and a distance of exactly zero.
    task automatic test_saturation();
        program_wall('{32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 40'h00_0000_0000,
                       18'h3_0000, 18'h1_FFFF, 18'h2_0000});
        send_particle(40'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_particle(40'd0, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        send_particle(40'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();
        program_wall('{32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 40'h00_0000_0000,
                       18'h3_0000, 18'h1_FFFF, 18'h2_0000});
        send_particle(40'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        wait_drained();
    endtask

    // Unnormalized tiny normal: the dot product rounds toward minus infinity.
    task automatic test_dot_rounding();
        program_wall('{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 40'h00_0000_0000,
                       18'h0_0001, 18'h3_FFFF, 18'h0_0003});
        send_particle(40'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_particle(40'd0, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        send_particle(40'd0, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
        send_particle(40'd0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000);
        send_particle(40'd0, 32'hFFFE_FFFF, 32'h0000_0000, 32'h0000_0000);
        wait_drained();
    endtask

    // Random settings per phase, random particles near and far from the plane.
    task automatic test_random_traffic();
        logic [STEP_W-1:0] sim_step;
        logic [POS_W-1:0]  px, py, pz;
        bit                near;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            program_wall(random_wall());
            send_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
            recv_idle_on = (phase % 4 == 0) || (phase % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 3))
                    0:       sim_step = STEP_W'($urandom_range(0, 1000));
                    1:       sim_step = STEP_W'($urandom);
                    default: sim_step = STEP_W'({$urandom, $urandom});
                endcase
                near = ($urandom_range(0, 9) < 6);
                px = near ? 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000 : $urandom;
                py = near ? 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000 : $urandom;
                pz = near ? 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000 : $urandom;
                send_particle(sim_step, px, py, pz);
                // Hold the sender until the pipeline has emptied now and then.
                if (n == ITEMS_PER_PHASE / 2 && phase % 3 == 0) begin
                    wait_drained();
                end
            end
            wait_drained();
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_plane_motion();
        test_saturation();
        test_dot_rounding();
        test_random_traffic();
        wait_drained();
        repeat (NSTG * 3) @(posedge i_clk);
        if (mismatch_count == 0 && expected_resp.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
